FILE: sv/isl_pkg.sv
// ---------------------------------------------------------------------------
// isl_pkg
// Shared types and codes for the indexed shift list: command and status
// codes, transfer payloads and the control word broadcast to every cell.
// ---------------------------------------------------------------------------
`default_nettype none

package isl_pkg;

    localparam logic [2:0] CMD_APPEND      = 3'd0;
    localparam logic [2:0] CMD_INSERT      = 3'd1;
    localparam logic [2:0] CMD_READ        = 3'd2;
    localparam logic [2:0] CMD_REMOVE      = 3'd3;
    localparam logic [2:0] CMD_REMOVE_LAST = 3'd4;
    localparam logic [2:0] CMD_FIND        = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_BAD_INDEX = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [5:0]  slot;
        logic [31:0] item;
    } t_isl_in;

    typedef struct packed {
        logic [31:0] read_value;
        logic [5:0]  found_slot;
        logic        found;
        logic [6:0]  fill_count;
        logic [2:0]  status;
    } t_isl_out;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_APPEND = 2'd1,
        OP_INSERT = 2'd2,
        OP_REMOVE = 2'd3
    } t_isl_op;

    typedef struct packed {
        t_isl_op    op;
        logic [5:0] slot;
        logic       rd_last;
    } t_isl_ctl;

endpackage

`default_nettype wire

FILE: sv/isl_cell.sv
// ---------------------------------------------------------------------------
// isl_cell
// One list position. Holds one entry, loads the new item, takes its left
// neighbor on an insert or its right neighbor on a remove, and reports a
// match against the search value and its entry when selected.
// ---------------------------------------------------------------------------
`default_nettype none

module isl_cell
    import isl_pkg::*;
#(
    parameter int EW  = 32,
    parameter int CW  = 7,
    parameter int IDX = 0
) (
    input  wire logic          i_clk,
    input  wire t_isl_ctl      i_ctl,
    input  wire logic [CW-1:0] i_count,
    input  wire logic [EW-1:0] i_item,
    input  wire logic [EW-1:0] i_left,
    input  wire logic [EW-1:0] i_right,
    output logic      [EW-1:0] o_value,
    output logic               o_match,
    output logic      [EW-1:0] o_sel_value
);

    localparam int XW = CW + 6;

    logic [EW-1:0] r_value;
    logic [EW-1:0] n_value;
    logic [XW-1:0] idx_x;
    logic [XW-1:0] slot_x;
    logic [XW-1:0] cnt_x;
    logic          sel;

    assign idx_x  = XW'(IDX);
    assign slot_x = XW'(i_ctl.slot);
    assign cnt_x  = XW'(i_count);

    always_comb begin
        n_value = r_value;
        unique case (i_ctl.op)
            OP_APPEND: begin
                if (idx_x == cnt_x) begin
                    n_value = i_item;
                end
            end
            OP_INSERT: begin
                if (idx_x == slot_x) begin
                    n_value = i_item;
                end else if ((idx_x > slot_x) && (idx_x <= cnt_x)) begin
                    n_value = i_left;
                end
            end
            OP_REMOVE: begin
                if ((idx_x >= slot_x) && ((idx_x + 1'b1) < cnt_x)) begin
                    n_value = i_right;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign sel         = i_ctl.rd_last ? ((idx_x + 1'b1) == cnt_x) : (idx_x == slot_x);
    assign o_value     = r_value;
    assign o_match     = (r_value == i_item) && (idx_x < cnt_x);
    assign o_sel_value = sel ? r_value : '0;

endmodule

`default_nettype wire

FILE: sv/indexed_shift_list.sv
// ---------------------------------------------------------------------------
// indexed_shift_list
// Bounded ordered list of element handles held in a row of shifting cells.
// ---------------------------------------------------------------------------
// Usage:
//   Commands arrive on the input channel (i_in_valid / o_in_stall, payload
//   i_in_data) and each produces exactly one result on the output channel
//   (o_out_valid / i_out_stall, payload o_out_data).
//   Append, insert, read, remove and remove-last complete at the edge that
//   accepts them; the result is valid in the next cycle, one command per
//   cycle while the output is free and no find is searching. Insert and
//   remove shift the cells from the slot to the end of the list at once.
//   Find registers the cell match vector when accepted; the search state
//   priority encodes it once the output is free and accepts no command.
//   A waiting result is held in the output register while i_out_stall is
//   high; a new command is accepted only once that register is free or is
//   being emptied in the same cycle.
//   Reset empties the list (count zero) and drops any pending result; entry
//   contents are not cleared and are never visible before they are written.
// ---------------------------------------------------------------------------
`default_nettype none

module indexed_shift_list
    import isl_pkg::*;
#(
    parameter int CAPACITY      = 64,
    parameter int ELEMENT_WIDTH = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_isl_in  i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_isl_out      o_out_data
);

    localparam int EW = ELEMENT_WIDTH;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int XW = CW + 6;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SEARCH = 2'b10
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_out_valid, n_out_valid;
    t_isl_out              r_out, n_out;
    logic [CAPACITY-1:0]   r_match, n_match;

    logic                  accept;
    logic                  out_free;
    t_isl_ctl              ctl;
    logic [EW+31:0]        item_wide;
    logic [EW-1:0]         item_ew;
    logic [XW-1:0]         slot_x;
    logic [XW-1:0]         count_x;
    logic                  full;
    logic                  empty;
    logic                  bad_ins;
    logic                  bad_idx;
    logic [EW-1:0]         sel_or;
    logic [EW+31:0]        sel_wide;
    logic [31:0]           sel_32;
    logic [CW+6:0]         count_wide;
    logic [CW+6:0]         n_count_wide;
    logic [CAPACITY-1:0]   hit_vec;
    logic [CAPACITY-1:0]   first_hit;
    logic [IW-1:0]         hit_idx;
    logic [IW+5:0]         hit_wide;

    logic [EW-1:0]         w_value [CAPACITY];
    logic [EW-1:0]         w_left  [CAPACITY];
    logic [EW-1:0]         w_right [CAPACITY];
    logic [EW-1:0]         w_sel   [CAPACITY];

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state == ST_SEARCH) || !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    assign item_wide = {{EW{1'b0}}, i_in_data.item};
    assign item_ew   = item_wide[EW-1:0];
    assign slot_x    = XW'(i_in_data.slot);
    assign count_x   = XW'(r_count);
    assign full      = (count_x >= XW'(CAPACITY));
    assign empty     = (r_count == '0);
    assign bad_ins   = (slot_x > count_x);
    assign bad_idx   = (slot_x >= count_x);

    always_comb begin
        ctl.op      = OP_HOLD;
        ctl.slot    = i_in_data.slot;
        ctl.rd_last = (i_in_data.cmd == CMD_REMOVE_LAST);
        if (accept) begin
            case (i_in_data.cmd)
                CMD_APPEND: begin
                    if (!full) begin
                        ctl.op = OP_APPEND;
                    end
                end
                CMD_INSERT: begin
                    if (!full && !bad_ins) begin
                        ctl.op = OP_INSERT;
                    end
                end
                CMD_REMOVE: begin
                    if (!bad_idx) begin
                        ctl.op = OP_REMOVE;
                    end
                end
                default: begin
                    ctl.op = OP_HOLD;
                end
            endcase
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g] = '0;
        end else begin : g_mid_l
            assign w_left[g] = w_value[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right[g] = '0;
        end else begin : g_mid_r
            assign w_right[g] = w_value[g+1];
        end

        isl_cell #(
            .EW  (EW),
            .CW  (CW),
            .IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_count     (r_count),
            .i_item      (item_ew),
            .i_left      (w_left[g]),
            .i_right     (w_right[g]),
            .o_value     (w_value[g]),
            .o_match     (hit_vec[g]),
            .o_sel_value (w_sel[g])
        );
    end

    always_comb begin
        sel_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            sel_or = sel_or | w_sel[i];
        end
    end

    assign sel_wide = {32'b0, sel_or};
    assign sel_32   = sel_wide[31:0];

    assign first_hit = r_match & (~r_match + 1'b1);

    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (first_hit[i]) begin
                hit_idx = hit_idx | IW'(i);
            end
        end
    end

    assign hit_wide   = {6'b0, hit_idx};
    assign count_wide = {7'b0, r_count};

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_match      = r_match;
        n_count_wide = count_wide;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_out            = '0;
                    n_out.status     = ST_OK;
                    case (i_in_data.cmd)
                        CMD_APPEND: begin
                            if (full) begin
                                n_out.status = ST_FULL;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_INSERT: begin
                            if (full) begin
                                n_out.status = ST_FULL;
                            end else if (bad_ins) begin
                                n_out.status = ST_BAD_INDEX;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_READ: begin
                            if (bad_idx) begin
                                n_out.status = ST_BAD_INDEX;
                            end else begin
                                n_out.read_value = sel_32;
                            end
                        end
                        CMD_REMOVE: begin
                            if (bad_idx) begin
                                n_out.status = ST_BAD_INDEX;
                            end else begin
                                n_out.read_value = sel_32;
                                n_count          = r_count - 1'b1;
                            end
                        end
                        CMD_REMOVE_LAST: begin
                            if (empty) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                n_out.read_value = sel_32;
                                n_count          = r_count - 1'b1;
                            end
                        end
                        default: begin
                            n_out.status = ST_OK;
                        end
                    endcase
                    n_count_wide     = {7'b0, n_count};
                    n_out.fill_count = n_count_wide[6:0];
                    if (i_in_data.cmd == CMD_FIND) begin
                        n_match     = hit_vec;
                        n_state     = ST_SEARCH;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            ST_SEARCH: begin
                if (out_free) begin
                    n_out            = '0;
                    n_out.fill_count = count_wide[6:0];
                    if (|r_match) begin
                        n_out.found      = 1'b1;
                        n_out.found_slot = hit_wide[5:0];
                        n_out.status     = ST_OK;
                    end else begin
                        n_out.status     = ST_NOT_FOUND;
                    end
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_match <= n_match;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_count) <= XW'(CAPACITY))
        else $error("fill count above capacity");

    a_find_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in_data.cmd == CMD_FIND)) |=> (r_state == ST_SEARCH))
        else $error("find did not enter search");

    a_search_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> !accept)
        else $error("transfer accepted during search");

    a_count_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_count))
        else $error("fill count changed without a transfer");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.found) |-> (o_out_data.status == ST_OK))
        else $error("found result without ok status");
`endif

endmodule

`default_nettype wire

FILE: test/tb_indexed_shift_list.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_indexed_shift_list
// Self-checking bench for the indexed shift list. A directed opening covers
// errors on an empty list, inserts at both ends and in the middle, reads,
// finds with duplicates and unused command codes. Random traffic follows,
// swinging the fill between empty and full. A predictor tracks the list
// contents and holds one expected result per command; the monitor compares
// each result field by field. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_indexed_shift_list;
    import isl_pkg::*;

    localparam int LIST_DEPTH     = 64;
    localparam int RANDOM_ITEMS   = 900;
    localparam int HOLD_AT        = 250;
    localparam int LONG_HOLD      = 90;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 4;

    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    localparam logic [31:0] HANDLE_POOL [8] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
        32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h1234_5678, 32'hDEAD_BEEF
    };

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_ANY} t_mix;

    typedef struct {
        logic [31:0] cells [LIST_DEPTH];
        int          fill;
    } t_list_state;

    typedef struct packed {
        logic    wait_idle;
        t_isl_in cmd;
    } t_cmd_entry;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    t_isl_in  i_in_data;
    logic     o_out_valid;
    logic     i_out_stall;
    t_isl_out o_out_data;

    t_cmd_entry  cmd_backlog [$];
    t_isl_out    want_results [$];
    t_list_state planned_list;
    t_list_state tracked_list;

    logic cmd_take;
    logic res_take;
    int   fail_count;
    int   quiet_cycles;
    int   send_gap;
    bit   send_burst;
    int   rcv_gap;
    bit   rcv_burst;
    int   rcv_taken;

    indexed_shift_list dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    function automatic t_isl_out list_apply(inout t_list_state s, input t_isl_in c);
        t_isl_out r;
        int       k;
        r = '0;
        case (c.cmd)
            CMD_APPEND: begin
                if (s.fill >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    s.cells[s.fill] = c.item;
                    s.fill++;
                end
            end
            CMD_INSERT: begin
                if (s.fill >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else if (c.slot > s.fill) begin
                    r.status = ST_BAD_INDEX;
                end else begin
                    for (k = s.fill; k > c.slot; k--)
                        s.cells[k] = s.cells[k - 1];
                    s.cells[c.slot] = c.item;
                    s.fill++;
                end
            end
            CMD_READ: begin
                if (c.slot >= s.fill)
                    r.status = ST_BAD_INDEX;
                else
                    r.read_value = s.cells[c.slot];
            end
            CMD_REMOVE: begin
                if (c.slot >= s.fill) begin
                    r.status = ST_BAD_INDEX;
                end else begin
                    r.read_value = s.cells[c.slot];
                    for (k = c.slot; k + 1 < s.fill; k++)
                        s.cells[k] = s.cells[k + 1];
                    s.fill--;
                end
            end
            CMD_REMOVE_LAST: begin
                if (s.fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    s.fill--;
                    r.read_value = s.cells[s.fill];
                end
            end
            CMD_FIND: begin
                r.status = ST_NOT_FOUND;
                for (k = 0; k < s.fill; k++) begin
                    if (!r.found && s.cells[k] == c.item) begin
                        r.found      = 1'b1;
                        r.found_slot = k[5:0];
                        r.status     = ST_OK;
                    end
                end
            end
            default: ;
        endcase
        r.fill_count = s.fill[6:0];
        return r;
    endfunction

    function automatic logic [2:0] pick_op(input t_mix mix);
        int cut [6];
        int roll;
        case (mix)
            MIX_GROW:   cut = '{30, 60, 72, 84, 92, 97};
            MIX_SHRINK: cut = '{8, 16, 28, 40, 70, 97};
            default:    cut = '{17, 34, 50, 66, 82, 97};
        endcase
        roll = $urandom_range(0, 99);
        if (roll < cut[0]) return CMD_APPEND;
        if (roll < cut[1]) return CMD_INSERT;
        if (roll < cut[2]) return CMD_READ;
        if (roll < cut[3]) return CMD_FIND;
        if (roll < cut[4]) return CMD_REMOVE;
        if (roll < cut[5]) return CMD_REMOVE_LAST;
        return ($urandom_range(0, 1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
    endfunction

    function automatic logic [31:0] pick_item();
        if ($urandom_range(0, 99) < 35) return HANDLE_POOL[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    task automatic queue_cmd(input logic [2:0] op, input logic [5:0] slot,
                             input logic [31:0] item, input logic wait_idle);
        t_isl_in c;
        c.cmd  = op;
        c.slot = slot;
        c.item = item;
        void'(list_apply(planned_list, c));
        cmd_backlog.push_back('{wait_idle, c});
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // opening, then random traffic, then drain and verdict
    initial begin
        t_mix        mix;
        int          mix_left;
        int          placed;
        int          fill;
        logic [2:0]  op;
        logic [5:0]  slot;
        logic [31:0] item;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        fail_count  = 0;
        planned_list.fill = 0;
        tracked_list.fill = 0;

        queue_cmd(CMD_REMOVE_LAST, 6'd0, 32'h0, 1'b0);
        queue_cmd(CMD_READ, 6'd0, 32'h0, 1'b0);
        queue_cmd(CMD_REMOVE, 6'd0, 32'h0, 1'b0);
        queue_cmd(CMD_FIND, 6'd0, 32'h0, 1'b0);
        queue_cmd(CMD_INSERT, 6'd1, 32'h1, 1'b0);
        queue_cmd(CMD_INSERT, 6'd0, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(CMD_APPEND, 6'd0, 32'h0, 1'b0);
        queue_cmd(CMD_INSERT, 6'd1, 32'hA5A5_A5A5, 1'b0);
        queue_cmd(CMD_INSERT, 6'd3, 32'h5A5A_5A5A, 1'b0);
        queue_cmd(CMD_INSERT, 6'd0, 32'h0000_0001, 1'b0);
        queue_cmd(CMD_READ, 6'd4, 32'h0, 1'b0);
        queue_cmd(CMD_READ, 6'd5, 32'h0, 1'b0);
        queue_cmd(CMD_READ, 6'd63, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(CMD_FIND, 6'd63, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(CMD_APPEND, 6'd63, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(CMD_FIND, 6'd0, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(CMD_FIND, 6'd0, 32'h1234_5678, 1'b0);
        queue_cmd(CMD_REMOVE, 6'd1, 32'h0, 1'b0);
        queue_cmd(CMD_REMOVE, 6'd4, 32'h0, 1'b0);
        queue_cmd(CMD_REMOVE, 6'd63, 32'h0, 1'b0);
        queue_cmd(CMD_SPARE_LO, 6'($urandom), $urandom, 1'b0);
        queue_cmd(CMD_SPARE_HI, 6'd63, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(CMD_REMOVE_LAST, 6'd0, 32'h0, 1'b0);
        queue_cmd(CMD_REMOVE, 6'd0, 32'h0, 1'b0);
        queue_cmd(CMD_INSERT, 6'd63, 32'h8000_0000, 1'b0);

        mix      = MIX_GROW;
        mix_left = 6;
        placed   = 0;
        while (placed < RANDOM_ITEMS) begin
            fill = planned_list.fill;
            op   = pick_op(mix);
            slot = 6'($urandom_range(0, 63));
            item = pick_item();
            case (op)
                CMD_INSERT: begin
                    if ($urandom_range(0, 9) != 0)
                        slot = 6'($urandom_range(0, (fill > 63) ? 63 : fill));
                end
                CMD_READ, CMD_REMOVE: begin
                    if (fill > 0 && $urandom_range(0, 6) != 0)
                        slot = 6'($urandom_range(0, fill - 1));
                end
                CMD_FIND: begin
                    if (fill > 0 && $urandom_range(0, 9) < 7)
                        item = planned_list.cells[$urandom_range(0, fill - 1)];
                end
                default: ;
            endcase
            queue_cmd(op, slot, item, placed % 240 == 120);
            if (op != CMD_SPARE_LO && op != CMD_SPARE_HI)
                placed++;
            if (mix == MIX_ANY ||
                planned_list.fill == ((mix == MIX_GROW) ? LIST_DEPTH : 0))
                mix_left--;
            if (mix_left <= 0) begin
                mix      = t_mix'($urandom_range(0, 2));
                mix_left = (mix == MIX_ANY) ? 80 : 6;
            end
        end

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || want_results.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && want_results.size() == 0) begin
            $display("indexed_shift_list test passed");
        end else begin
            $display("indexed_shift_list test failed");
        end
        $finish;
    end

    // command driver
    always @(negedge i_clk) begin
        logic sending;
        sending = i_in_valid;
        if (sending && cmd_take) begin
            void'(cmd_backlog.pop_front());
            sending = 1'b0;
            if ($urandom_range(0, 39) == 0)
                send_burst = !send_burst;
            send_gap = send_burst ? 0 : $urandom_range(0, 10);
        end
        if (!sending && i_rst_n && cmd_backlog.size() != 0) begin
            if (send_gap != 0)
                send_gap--;
            else if (!cmd_backlog[0].wait_idle || want_results.size() == 0)
                sending = 1'b1;
        end
        i_in_valid <= sending;
        if (sending)
            i_in_data <= cmd_backlog[0].cmd;
    end

    // result receiver
    always @(negedge i_clk) begin
        if (res_take) begin
            rcv_taken++;
            if (rcv_taken == HOLD_AT) begin
                rcv_gap = LONG_HOLD;
            end else begin
                if ($urandom_range(0, 39) == 0)
                    rcv_burst = !rcv_burst;
                rcv_gap = rcv_burst ? 0 : $urandom_range(0, 10);
            end
        end
        i_out_stall <= (rcv_gap != 0);
        if (rcv_gap != 0)
            rcv_gap--;
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        t_isl_out want;
        cmd_take <= i_rst_n && i_in_valid && !o_in_stall;
        res_take <= i_rst_n && o_out_valid && !i_out_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (want_results.size() == 0) begin
                $error("result with no command pending: %p", o_out_data);
                fail_count++;
            end else begin
                want = want_results.pop_front();
                check_field("read_value", want.read_value, o_out_data.read_value);
                check_field("found_slot", 32'(want.found_slot), 32'(o_out_data.found_slot));
                check_field("found", 32'(want.found), 32'(o_out_data.found));
                check_field("fill_count", 32'(want.fill_count), 32'(o_out_data.fill_count));
                check_field("status", 32'(want.status), 32'(o_out_data.status));
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall)
            want_results.push_back(list_apply(tracked_list, i_in_data));
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("indexed_shift_list test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        cmd_take     = 1'b0;
        res_take     = 1'b0;
        quiet_cycles = 0;
        send_gap     = 0;
        send_burst   = 1'b0;
        rcv_gap      = 0;
        rcv_burst    = 1'b0;
        rcv_taken    = 0;
    end

endmodule

FILE: sim.f
sv/isl_pkg.sv
sv/isl_cell.sv
sv/indexed_shift_list.sv
test/tb_indexed_shift_list.sv
